FILE: hdl/ctl_pkg.sv
// Shared types, codes and constants of the coverage table lookup block.
`default_nettype none

package ctl_pkg;

  // Default size of the table byte store.
  localparam int TABLE_BYTES_DEFAULT = 8192;

  // Width of internal byte addresses and of the shared adder.
  localparam int PW = 20;

  // Result status codes.
  localparam logic [1:0] ST_WRITE   = 2'd0;
  localparam logic [1:0] ST_COVERED = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_BADFMT  = 2'd3;

  // Request command codes.
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Coverage table formats and layout.
  localparam logic [15:0] FMT_LIST  = 16'd1;
  localparam logic [15:0] FMT_RANGE = 16'd2;
  localparam int WORD_BYTES = 2;
  localparam int HDR_BYTES  = 4;
  localparam int REC_BYTES  = 6;

  typedef struct packed {
    logic [PW-1:0] a;
    logic [PW-1:0] b;
    logic          sub;
  } alu_req_t;

  typedef struct packed {
    logic [PW-1:0] sum;
    logic          neg;
    logic          zero;
  } alu_rsp_t;

  typedef struct packed {
    logic          we;
    logic          re;
    logic [PW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;

  typedef struct packed {
    logic        done;
    logic [1:0]  status;
    logic [16:0] index;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/ctl_alu.sv
// Shared add/subtract unit with sign and zero flags.
`default_nettype none

module ctl_alu (
  input  ctl_pkg::alu_req_t req,
  output ctl_pkg::alu_rsp_t rsp
);

  logic [ctl_pkg::PW-1:0] sum;

  assign sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.sum  = sum;
  assign rsp.neg  = sum[ctl_pkg::PW-1];
  assign rsp.zero = (sum == '0);

endmodule

`default_nettype wire

FILE: hdl/ctl_store.sv
// Table byte store: one write or read port, registered read data.
`default_nettype none

module ctl_store #(
  parameter int TABLE_BYTES = ctl_pkg::TABLE_BYTES_DEFAULT
) (
  input  logic              clk,
  input  ctl_pkg::mem_req_t req,
  output logic [7:0]        rdata
);

  localparam int AW = $clog2(TABLE_BYTES);

  logic [7:0] mem [TABLE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[AW-1:0]] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr[AW-1:0]];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ctl_seq.sv
// Sequencer that walks a coverage table with the shared adder and byte port.
`default_nettype none

module ctl_seq #(
  parameter int TABLE_BYTES = ctl_pkg::TABLE_BYTES_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              cmd,
  input  logic [12:0]       write_address,
  input  logic [7:0]        write_byte,
  input  logic [12:0]       table_offset,
  input  logic [15:0]       glyph,
  output logic              busy,
  input  logic              out_free,
  output ctl_pkg::res_t     res,
  output ctl_pkg::mem_req_t mem,
  input  logic [7:0]        rdata,
  output ctl_pkg::alu_req_t alu_req,
  input  ctl_pkg::alu_rsp_t alu_rsp
);

  localparam int PW = ctl_pkg::PW;
  localparam logic [PW:0] LIMIT = (PW+1)'(TABLE_BYTES);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_FIN    = 5'd1;
  localparam logic [4:0] S_F0     = 5'd2;
  localparam logic [4:0] S_F1     = 5'd3;
  localparam logic [4:0] S_FMT    = 5'd4;
  localparam logic [4:0] S_CNT    = 5'd5;
  localparam logic [4:0] S_BINIT  = 5'd6;
  localparam logic [4:0] S_BCHK   = 5'd7;
  localparam logic [4:0] S_BMID   = 5'd8;
  localparam logic [4:0] S_BADR   = 5'd9;
  localparam logic [4:0] S_BCMP   = 5'd10;
  localparam logic [4:0] S_BLO    = 5'd11;
  localparam logic [4:0] S_BHI    = 5'd12;
  localparam logic [4:0] S_RCHK   = 5'd13;
  localparam logic [4:0] S_RSTART = 5'd14;
  localparam logic [4:0] S_REND   = 5'd15;
  localparam logic [4:0] S_RSCI   = 5'd16;
  localparam logic [4:0] S_RLE    = 5'd17;
  localparam logic [4:0] S_RHIT   = 5'd18;
  localparam logic [4:0] S_RNEXT  = 5'd19;
  localparam logic [4:0] S_RINC   = 5'd20;

  logic [4:0]    state;
  logic [4:0]    ret;
  logic [PW-1:0] wa;
  logic          wok;
  logic [7:0]    hi_byte;
  logic [PW-1:0] base;
  logic [15:0]   gid;
  logic          is_list;
  logic [15:0]   count;
  logic [PW-1:0] lo;
  logic [PW-1:0] hi_idx;
  logic [PW-1:0] mid;
  logic [PW-1:0] rec;
  logic [15:0]   rec_num;
  logic [15:0]   range_start;
  logic [15:0]   range_end;
  logic [15:0]   sci;
  logic [15:0]   diff;
  logic [1:0]    res_status;
  logic [16:0]   res_index;

  logic [PW:0]   wa_inc;
  logic [15:0]   word;
  logic          write_ok;

  assign wa_inc   = {1'b0, wa} + (PW+1)'(1);
  // Words that reach past the end of the store read as zero.
  assign word     = wok ? {hi_byte, rdata} : 16'd0;
  assign write_ok = ((PW+1)'(write_address) < LIMIT);
  assign busy     = (state != S_IDLE);

  assign res.done   = (state == S_FIN) && out_free;
  assign res.status = res_status;
  assign res.index  = res_index;

  always_comb begin
    mem.we    = 1'b0;
    mem.re    = 1'b0;
    mem.addr  = wa;
    mem.wdata = write_byte;
    unique case (state)
      S_IDLE: begin
        mem.we   = in_valid && (cmd == ctl_pkg::CMD_WRITE) && write_ok;
        mem.addr = PW'(write_address);
      end
      S_F0: begin
        mem.re = 1'b1;
      end
      S_F1: begin
        mem.re   = 1'b1;
        mem.addr = wa_inc[PW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    unique case (state)
      S_FMT: begin
        alu_req.a = base;
        alu_req.b = PW'(ctl_pkg::WORD_BYTES);
      end
      S_CNT: begin
        alu_req.a = base;
        alu_req.b = PW'(ctl_pkg::HDR_BYTES);
      end
      S_BINIT: begin
        alu_req.a   = PW'(count);
        alu_req.b   = PW'(1);
        alu_req.sub = 1'b1;
      end
      S_BCHK: begin
        alu_req.a   = hi_idx;
        alu_req.b   = lo;
        alu_req.sub = 1'b1;
      end
      S_BMID: begin
        alu_req.a = lo;
        alu_req.b = hi_idx;
      end
      S_BADR: begin
        alu_req.a = rec;
        alu_req.b = {mid[PW-2:0], 1'b0};
      end
      S_BCMP: begin
        alu_req.a   = PW'(word);
        alu_req.b   = PW'(gid);
        alu_req.sub = 1'b1;
      end
      S_BLO: begin
        alu_req.a = mid;
        alu_req.b = PW'(1);
      end
      S_BHI: begin
        alu_req.a   = mid;
        alu_req.b   = PW'(1);
        alu_req.sub = 1'b1;
      end
      S_RCHK: begin
        alu_req.a   = PW'(rec_num);
        alu_req.b   = PW'(count);
        alu_req.sub = 1'b1;
      end
      S_RSTART: begin
        alu_req.a = rec;
        alu_req.b = PW'(ctl_pkg::WORD_BYTES);
      end
      S_REND: begin
        alu_req.a = rec;
        alu_req.b = PW'(ctl_pkg::HDR_BYTES);
      end
      S_RSCI: begin
        alu_req.a   = PW'(gid);
        alu_req.b   = PW'(range_start);
        alu_req.sub = 1'b1;
      end
      S_RLE: begin
        alu_req.a   = PW'(range_end);
        alu_req.b   = PW'(gid);
        alu_req.sub = 1'b1;
      end
      S_RHIT: begin
        alu_req.a = PW'(sci);
        alu_req.b = PW'(diff);
      end
      S_RNEXT: begin
        alu_req.a = rec;
        alu_req.b = PW'(ctl_pkg::REC_BYTES);
      end
      S_RINC: begin
        alu_req.a = PW'(rec_num);
        alu_req.b = PW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_index <= '0;
            if (cmd == ctl_pkg::CMD_WRITE) begin
              res_status <= ctl_pkg::ST_WRITE;
              state      <= S_FIN;
            end else begin
              base  <= PW'(table_offset);
              wa    <= PW'(table_offset);
              gid   <= glyph;
              ret   <= S_FMT;
              state <= S_F0;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_F0: begin
          wok   <= (wa_inc < LIMIT);
          state <= S_F1;
        end
        S_F1: begin
          hi_byte <= rdata;
          state   <= ret;
        end
        S_FMT: begin
          is_list <= (word == ctl_pkg::FMT_LIST);
          if (word == ctl_pkg::FMT_LIST || word == ctl_pkg::FMT_RANGE) begin
            wa    <= alu_rsp.sum;
            ret   <= S_CNT;
            state <= S_F0;
          end else begin
            res_status <= ctl_pkg::ST_BADFMT;
            state      <= S_FIN;
          end
        end
        S_CNT: begin
          count <= word;
          rec   <= alu_rsp.sum;
          if (is_list) begin
            state <= S_BINIT;
          end else begin
            rec_num <= '0;
            state   <= S_RCHK;
          end
        end
        S_BINIT: begin
          hi_idx <= alu_rsp.sum;
          lo     <= '0;
          state  <= S_BCHK;
        end
        S_BCHK: begin
          if (alu_rsp.neg) begin
            res_status <= ctl_pkg::ST_MISSING;
            state      <= S_FIN;
          end else begin
            state <= S_BMID;
          end
        end
        S_BMID: begin
          mid   <= {1'b0, alu_rsp.sum[PW-1:1]};
          state <= S_BADR;
        end
        S_BADR: begin
          wa    <= alu_rsp.sum;
          ret   <= S_BCMP;
          state <= S_F0;
        end
        S_BCMP: begin
          if (alu_rsp.zero) begin
            res_status <= ctl_pkg::ST_COVERED;
            res_index  <= mid[16:0];
            state      <= S_FIN;
          end else if (alu_rsp.neg) begin
            state <= S_BLO;
          end else begin
            state <= S_BHI;
          end
        end
        S_BLO: begin
          lo    <= alu_rsp.sum;
          state <= S_BCHK;
        end
        S_BHI: begin
          hi_idx <= alu_rsp.sum;
          state  <= S_BCHK;
        end
        S_RCHK: begin
          if (alu_rsp.neg) begin
            wa    <= rec;
            ret   <= S_RSTART;
            state <= S_F0;
          end else begin
            res_status <= ctl_pkg::ST_MISSING;
            state      <= S_FIN;
          end
        end
        S_RSTART: begin
          range_start <= word;
          wa          <= alu_rsp.sum;
          ret         <= S_REND;
          state       <= S_F0;
        end
        S_REND: begin
          range_end <= word;
          wa        <= alu_rsp.sum;
          ret       <= S_RSCI;
          state     <= S_F0;
        end
        S_RSCI: begin
          sci <= word;
          if (alu_rsp.neg) begin
            state <= S_RNEXT;
          end else begin
            diff  <= alu_rsp.sum[15:0];
            state <= S_RLE;
          end
        end
        S_RLE: begin
          state <= alu_rsp.neg ? S_RNEXT : S_RHIT;
        end
        S_RHIT: begin
          res_status <= ctl_pkg::ST_COVERED;
          res_index  <= alu_rsp.sum[16:0];
          state      <= S_FIN;
        end
        S_RNEXT: begin
          rec   <= alu_rsp.sum;
          state <= S_RINC;
        end
        S_RINC: begin
          rec_num <= alu_rsp.sum[15:0];
          state   <= S_RCHK;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/coverage_table_lookup.sv
// Top level of the coverage table lookup block with its result register.
//
// The block holds a byte store of font layout tables and answers coverage
// lookups against it. Each request on the input channel (in_valid/in_stall)
// is either a byte write (cmd 0) or a lookup (cmd 1) of a glyph in the
// coverage table that starts at table_offset. Every request gives exactly
// one result on the output channel (out_valid/out_stall).
// A write result passes from the finish state into the output register. A
// lookup first reads the format and count words, then, for format 1, runs a
// binary search (at most ceil(log2(count + 1)) probes); for format 2, it
// scans the range records in order. The result passes from the finish state
// into the output register when the search ends. The single shared adder does
// one address or compare step a cycle and the byte read port reads each
// big-endian word as two bytes, high byte first. One request is worked on at
// a time: in_stall is high from acceptance until the result has been loaded,
// so back-to-back writes each pass the finish state before the next is taken.
// When the receiver stalls, the result stays in the output register and a
// finished request waits in the sequencer until the register frees up.
// Synchronous reset returns the sequencer to idle and empties the output
// register; the store contents are undefined until written.
`default_nettype none

module coverage_table_lookup #(
  parameter int TABLE_BYTES = ctl_pkg::TABLE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [12:0] write_address,
  input  logic [7:0]  write_byte,
  input  logic [12:0] table_offset,
  input  logic [15:0] glyph,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [16:0] coverage_index
);

  ctl_pkg::res_t     seq_res;
  ctl_pkg::mem_req_t mem_req;
  ctl_pkg::alu_req_t alu_req;
  ctl_pkg::alu_rsp_t alu_rsp;
  logic [7:0]        rdata;
  logic              out_free;

  // The output register can take a new result when it is empty or is being
  // drained at this edge.
  assign out_free = !out_valid || !out_stall;

  ctl_seq #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .cmd          (cmd),
    .write_address(write_address),
    .write_byte   (write_byte),
    .table_offset (table_offset),
    .glyph        (glyph),
    .busy         (in_stall),
    .out_free     (out_free),
    .res          (seq_res),
    .mem          (mem_req),
    .rdata        (rdata),
    .alu_req      (alu_req),
    .alu_rsp      (alu_rsp)
  );

  ctl_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  ctl_store #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_store (
    .clk  (clk),
    .req  (mem_req),
    .rdata(rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (seq_res.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_res.done) begin
      status         <= seq_res.status;
      coverage_index <= seq_res.index;
    end
  end

  // A request that has just been accepted keeps the input side closed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input side open right after a request was accepted");

  // The sequencer never hands over a result while the register is held.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    seq_res.done |-> out_free)
    else $error("result handed over while the output register was stalled");

  // Only a covered result carries a nonzero coverage index.
  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ctl_pkg::ST_COVERED |-> coverage_index == 17'd0)
    else $error("nonzero coverage index on a result that is not covered");

  // A finished result appears in the output register at the next edge.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    seq_res.done |=> out_valid && status == $past(seq_res.status))
    else $error("finished result did not reach the output register");

endmodule

`default_nettype wire
